/* hdl/dcc_pkg.sv */
`default_nettype none

package dcc_pkg;

   localparam int unsigned MaxBody = 4;

   localparam logic [1:0] MODE_14  = 2'd0;
   localparam logic [1:0] MODE_28  = 2'd1;
   localparam logic [1:0] MODE_128 = 2'd2;

   localparam logic [3:0] KIND_SPEED  = 4'd0;
   localparam logic [3:0] KIND_F0_4   = 4'd1;
   localparam logic [3:0] KIND_F5_8   = 4'd2;
   localparam logic [3:0] KIND_F9_12  = 4'd3;
   localparam logic [3:0] KIND_F13_20 = 4'd4;
   localparam logic [3:0] KIND_F21_28 = 4'd5;
   localparam logic [3:0] KIND_F29_36 = 4'd6;
   localparam logic [3:0] KIND_F37_44 = 4'd7;
   localparam logic [3:0] KIND_F45_52 = 4'd8;
   localparam logic [3:0] KIND_F53_60 = 4'd9;
   localparam logic [3:0] KIND_F61_68 = 4'd10;

   typedef struct packed {
      logic [13:0] loco_address;
      logic [1:0]  step_mode;
      logic        forward;
      logic [6:0]  speed_step;
      logic [63:0] function_bits_low;
      logic [4:0]  function_bits_high;
      logic [3:0]  packet_kind;
   } dcc_req_type;

   // body bytes in transmission order, unused bytes zero
   typedef struct packed {
      logic [MaxBody-1:0][7:0] body;
      logic [2:0]              body_len;
      logic [7:0]              chk;
   } dcc_pkt_type;

endpackage

`default_nettype wire

/* hdl/dcc_packet_encoder.sv */
// the first byte of a packet passes through the request register, then the byte output register
// throughput: one packet byte per cycle while rsp_stall is low; a packet of n
//    bytes (3 to 5) holds the request register until its checksum byte is
//    loaded in the single byte output register, as the next request is taken
// reset: synchronous, active high; clears the request and result valid flags
`default_nettype none

module dcc_packet_encoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [13:0] req_loco_address,
   input  wire logic [1:0]  req_step_mode,
   input  wire logic        req_forward,
   input  wire logic [6:0]  req_speed_step,
   input  wire logic [63:0] req_function_bits_low,
   input  wire logic [4:0]  req_function_bits_high,
   input  wire logic [3:0]  req_packet_kind,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_packet_byte,
   output      logic [2:0]  rsp_byte_position,
   output      logic        rsp_last_byte
);
   import dcc_pkg::*;

   logic        in_valid_ff, in_valid_in;
   dcc_req_type req_ff, req_in;
   logic [2:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic [2:0]  pos_ff, pos_in;
   logic        last_ff, last_in;

   dcc_pkt_type pkt;
   logic        out_free;
   logic        load_out;
   logic        at_chk;
   logic        req_xfer;

   dcc_pkt_build u_build (
      .req (req_ff),
      .pkt (pkt)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_out  = in_valid_ff && out_free;
   assign at_chk    = (idx_ff == pkt.body_len);
   assign req_stall = in_valid_ff && !(load_out && at_chk);
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = in_valid_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;

      if (out_free) begin
         rsp_valid_in = load_out;
      end
      if (load_out) begin
         byte_in = at_chk ? pkt.chk : pkt.body[idx_ff[1:0]];
         pos_in  = idx_ff;
         last_in = at_chk;
         idx_in  = at_chk ? 3'd0 : idx_ff + 3'd1;
         if (at_chk) begin
            in_valid_in = 1'b0;
         end
      end
      if (req_xfer) begin
         in_valid_in            = 1'b1;
         req_in.loco_address       = req_loco_address;
         req_in.step_mode          = req_step_mode;
         req_in.forward            = req_forward;
         req_in.speed_step         = req_speed_step;
         req_in.function_bits_low  = req_function_bits_low;
         req_in.function_bits_high = req_function_bits_high;
         req_in.packet_kind        = req_packet_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      byte_ff <= byte_in;
      pos_ff  <= pos_in;
      last_ff <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_packet_byte   = byte_ff;
   assign rsp_byte_position = pos_ff;
   assign rsp_last_byte     = last_ff;

   // a packet has at least address, instruction and checksum
   a_min_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> pos_ff >= 3'd2)
      else $error("checksum byte too early in packet");

   // bytes of one packet follow without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !last_ff |=>
         rsp_valid_ff && pos_ff == 3'($past(pos_ff) + 3'd1))
      else $error("gap or skip inside packet");

   // no new request while a packet is half sent
   a_hold_req: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && idx_ff != 3'd0 && !at_chk |-> req_stall)
      else $error("request taken mid packet");

endmodule

`default_nettype wire

/* hdl/dcc_pkt_build.sv */
`default_nettype none

module dcc_pkt_build (
   input  dcc_pkg::dcc_req_type req,
   output dcc_pkg::dcc_pkt_type pkt
);
   import dcc_pkg::*;

   always_comb begin
      logic        long_addr;
      logic [7:0]  ins0;
      logic [7:0]  ins1;
      logic        ins_two;
      logic [6:0]  s128;
      logic [6:0]  c128;
      logic [4:0]  s28;
      logic [4:0]  t28;
      logic [3:0]  s14;
      logic [3:0]  c14;
      logic [68:0] fall;
      logic [7:0]  oct;
      logic [7:0]  ecmd;
      logic        is_ext;

      long_addr = (req.loco_address[13:7] != 7'd0);
      fall      = {req.function_bits_high, req.function_bits_low};

      s128 = (req.speed_step > 7'd126) ? 7'd126 : req.speed_step;
      c128 = (s128 == 7'd0) ? 7'd0 : s128 + 7'd1;
      s28  = (req.speed_step > 7'd28) ? 5'd28 : req.speed_step[4:0];
      t28  = (s28 == 5'd0) ? 5'd0 : s28 + 5'd3;
      s14  = (req.speed_step > 7'd14) ? 4'd14 : req.speed_step[3:0];
      c14  = (s14 == 4'd0) ? 4'd0 : s14 + 4'd1;

      is_ext = 1'b1;
      oct    = 8'h00;
      ecmd   = 8'h00;
      case (req.packet_kind)
         KIND_F13_20: begin ecmd = 8'hde; oct = fall[13 +: 8]; end
         KIND_F21_28: begin ecmd = 8'hdf; oct = fall[21 +: 8]; end
         KIND_F29_36: begin ecmd = 8'hd8; oct = fall[29 +: 8]; end
         KIND_F37_44: begin ecmd = 8'hd9; oct = fall[37 +: 8]; end
         KIND_F45_52: begin ecmd = 8'hda; oct = fall[45 +: 8]; end
         KIND_F53_60: begin ecmd = 8'hdb; oct = fall[53 +: 8]; end
         KIND_F61_68: begin ecmd = 8'hdc; oct = fall[61 +: 8]; end
         default:     is_ext = 1'b0;
      endcase

      ins0    = 8'h00;
      ins1    = 8'h00;
      ins_two = 1'b0;
      if (is_ext) begin
         ins0    = ecmd;
         ins1    = oct;
         ins_two = 1'b1;
      end else begin
         case (req.packet_kind)
            KIND_F0_4: ins0 = 8'h80 | {3'b000, req.function_bits_low[0],
                                      req.function_bits_low[4:1]};
            KIND_F5_8: ins0 = 8'hb0 | {4'h0, req.function_bits_low[8:5]};
            KIND_F9_12: ins0 = 8'ha0 | {4'h0, req.function_bits_low[12:9]};
            default: begin
               // speed and direction, also for kinds beyond the list
               case (req.step_mode)
                  MODE_128: begin
                     ins0    = 8'h3f;
                     ins1    = {req.forward, c128};
                     ins_two = 1'b1;
                  end
                  MODE_28: ins0 = 8'h40 | {2'b00, req.forward, t28[0], t28[4:1]};
                  default: ins0 = 8'h40 | {2'b00, req.forward,
                                          req.function_bits_low[0], c14};
               endcase
            end
         endcase
      end

      if (long_addr) begin
         pkt.body[0]  = 8'hc0 | {2'b00, req.loco_address[13:8]};
         pkt.body[1]  = req.loco_address[7:0];
         pkt.body[2]  = ins0;
         pkt.body[3]  = ins1;
         pkt.body_len = ins_two ? 3'd4 : 3'd3;
      end else begin
         pkt.body[0]  = req.loco_address[7:0];
         pkt.body[1]  = ins0;
         pkt.body[2]  = ins1;
         pkt.body[3]  = 8'h00;
         pkt.body_len = ins_two ? 3'd3 : 3'd2;
      end
      pkt.chk = pkt.body[0] ^ pkt.body[1] ^ pkt.body[2] ^ pkt.body[3];
   end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none

module tb_top;
   import dcc_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned HOLD_CYCLES  = 80;
   localparam int unsigned RANDOM_ITEMS = 136;
   localparam int unsigned DRAIN_CYCLES = 10;

   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [3:0] KIND_LAST  = 4'd15;

   localparam logic [7:0] INSTR_128_STEP = 8'h3f;
   localparam logic [7:0] GRP_F13_20     = 8'hde;
   localparam logic [7:0] GRP_F21_28     = 8'hdf;
   localparam logic [7:0] GRP_F29_36     = 8'hd8;
   localparam logic [7:0] GRP_F37_44     = 8'hd9;
   localparam logic [7:0] GRP_F45_52     = 8'hda;
   localparam logic [7:0] GRP_F53_60     = 8'hdb;
   localparam logic [7:0] GRP_F61_68     = 8'hdc;

   typedef struct packed {
      logic [7:0] value;
      logic [2:0] position;
      logic       last;
   } packet_byte_type;

   typedef logic [7:0] octet_queue_type[$];

   class packet_scoreboard;
      packet_byte_type expected_bytes[$];
      int unsigned     mismatches;
      int unsigned     packets_noted;
      int unsigned     bytes_checked;
      int unsigned     long_address_packets;
      logic [15:0]     kinds_noted;

      function logic [7:0] group_command(logic [3:0] kind);
         case (kind)
            KIND_F13_20: return GRP_F13_20;
            KIND_F21_28: return GRP_F21_28;
            KIND_F29_36: return GRP_F29_36;
            KIND_F37_44: return GRP_F37_44;
            KIND_F45_52: return GRP_F45_52;
            KIND_F53_60: return GRP_F53_60;
            default:     return GRP_F61_68;
         endcase
      endfunction

      function void encode_packet(input dcc_req_type r, output octet_queue_type body);
         logic [6:0]  spd;
         logic [4:0]  s28;
         logic [68:0] funcs;
         logic [7:0]  chk;
         int unsigned first;
         body = {};
         funcs = {r.function_bits_high, r.function_bits_low};
         if (r.loco_address < 14'd128) begin
            body.push_back({1'b0, r.loco_address[6:0]});
         end else begin
            body.push_back({2'b11, r.loco_address[13:8]});
            body.push_back(r.loco_address[7:0]);
         end
         if (r.packet_kind == KIND_SPEED || r.packet_kind > KIND_F61_68) begin
            spd = r.speed_step;
            case (r.step_mode)
               MODE_128: begin
                  if (spd > 7'd126) spd = 7'd126;
                  body.push_back(INSTR_128_STEP);
                  body.push_back({r.forward, (spd == 7'd0) ? 7'd0 : spd + 7'd1});
               end
               MODE_28: begin
                  if (spd > 7'd28) spd = 7'd28;
                  s28 = (spd == 7'd0) ? 5'd0 : 5'(spd + 7'd3);
                  body.push_back({2'b01, r.forward, s28[0], s28[4:1]});
               end
               default: begin
                  if (spd > 7'd14) spd = 7'd14;
                  spd = (spd == 7'd0) ? 7'd0 : spd + 7'd1;
                  body.push_back({2'b01, r.forward, r.function_bits_low[0], spd[3:0]});
               end
            endcase
         end else if (r.packet_kind == KIND_F0_4) begin
            body.push_back({3'b100, r.function_bits_low[0], r.function_bits_low[4:1]});
         end else if (r.packet_kind == KIND_F5_8) begin
            body.push_back({4'hb, r.function_bits_low[8:5]});
         end else if (r.packet_kind == KIND_F9_12) begin
            body.push_back({4'ha, r.function_bits_low[12:9]});
         end else begin
            first = 13 + 8 * (int'(r.packet_kind) - int'(KIND_F13_20));
            body.push_back(group_command(r.packet_kind));
            body.push_back(funcs[first +: 8]);
         end
         chk = 8'h00;
         foreach (body[i]) chk ^= body[i];
         body.push_back(chk);
      endfunction

      function void note_request(dcc_req_type r);
         octet_queue_type body;
         packet_byte_type b;
         encode_packet(r, body);
         foreach (body[i]) begin
            b.value    = body[i];
            b.position = 3'(i);
            b.last     = (i == body.size() - 1);
            expected_bytes.push_back(b);
         end
         packets_noted++;
         if (r.loco_address >= 14'd128) long_address_packets++;
         kinds_noted[r.packet_kind] = 1'b1;
      endfunction

      function void check_byte(logic [7:0] value, logic [2:0] position, logic last);
         packet_byte_type exp_b;
         if (expected_bytes.size() == 0) begin
            $error("unexpected result transfer: byte %h position %0d last %b",
                   value, position, last);
            mismatches++;
            return;
         end
         exp_b = expected_bytes.pop_front();
         bytes_checked++;
         if (value !== exp_b.value) begin
            $error("packet_byte: expected %h, actual %h", exp_b.value, value);
            mismatches++;
         end
         if (position !== exp_b.position) begin
            $error("byte_position: expected %0d, actual %0d", exp_b.position, position);
            mismatches++;
         end
         if (last !== exp_b.last) begin
            $error("last_byte: expected %b, actual %b", exp_b.last, last);
            mismatches++;
         end
      endfunction

      function int unsigned outstanding();
         return expected_bytes.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [13:0] req_loco_address;
   logic [1:0]  req_step_mode;
   logic        req_forward;
   logic [6:0]  req_speed_step;
   logic [63:0] req_function_bits_low;
   logic [4:0]  req_function_bits_high;
   logic [3:0]  req_packet_kind;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_packet_byte;
   logic [2:0]  rsp_byte_position;
   logic        rsp_last_byte;

   packet_scoreboard sb = new;
   bit               hold_results;
   bit               no_gaps;
   int unsigned      cycle_count = 0;

   dcc_packet_encoder uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_loco_address       (req_loco_address),
      .req_step_mode          (req_step_mode),
      .req_forward            (req_forward),
      .req_speed_step         (req_speed_step),
      .req_function_bits_low  (req_function_bits_low),
      .req_function_bits_high (req_function_bits_high),
      .req_packet_kind        (req_packet_kind),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_packet_byte        (rsp_packet_byte),
      .rsp_byte_position      (rsp_byte_position),
      .rsp_last_byte          (rsp_last_byte)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // transfer monitors
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_request({req_loco_address, req_step_mode, req_forward, req_speed_step,
                          req_function_bits_low, req_function_bits_high, req_packet_kind});
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_byte(rsp_packet_byte, rsp_byte_position, rsp_last_byte);
   end

   function automatic int unsigned gap_length();
      int unsigned r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   initial begin
      int unsigned n;
      bit          hold_done;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_results && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
            rsp_stall <= 1'b0;
         end else begin
            n = gap_length();
            if (n == 0) begin
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   task automatic offer_request(input dcc_req_type r);
      int unsigned n;
      req_valid              <= 1'b1;
      req_loco_address       <= r.loco_address;
      req_step_mode          <= r.step_mode;
      req_forward            <= r.forward;
      req_speed_step         <= r.speed_step;
      req_function_bits_low  <= r.function_bits_low;
      req_function_bits_high <= r.function_bits_high;
      req_packet_kind        <= r.packet_kind;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n = gap_length();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic offer_fields(input logic [13:0] addr, input logic [1:0] mode,
                               input logic fwd, input logic [6:0] spd,
                               input logic [63:0] flo, input logic [4:0] fhi,
                               input logic [3:0] kind);
      offer_request({addr, mode, fwd, spd, flo, fhi, kind});
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   function automatic dcc_req_type random_request();
      dcc_req_type r;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 3)      r.loco_address = 14'($urandom_range(0, 127));
      else if (pick < 9) r.loco_address = 14'($urandom_range(128, 10239));
      else               r.loco_address = 14'($urandom);
      r.step_mode = ($urandom_range(0, 9) == 0) ? MODE_SPARE : 2'($urandom_range(0, 2));
      r.forward = 1'($urandom);
      if ($urandom_range(0, 1) == 0) begin
         r.speed_step = 7'($urandom);
      end else begin
         case ($urandom_range(0, 7))
            0: r.speed_step = 7'd0;
            1: r.speed_step = 7'd1;
            2: r.speed_step = 7'd14;
            3: r.speed_step = 7'd15;
            4: r.speed_step = 7'd28;
            5: r.speed_step = 7'd29;
            6: r.speed_step = 7'd126;
            default: r.speed_step = 7'd127;
         endcase
      end
      r.function_bits_low  = {$urandom, $urandom};
      r.function_bits_high = 5'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30)      r.packet_kind = KIND_SPEED;
      else if (pick < 88) r.packet_kind = 4'($urandom_range(KIND_F0_4, KIND_F61_68));
      else                r.packet_kind = 4'($urandom_range(KIND_F61_68 + 1, KIND_LAST));
      return r;
   endfunction

   initial begin
      req_valid              <= 1'b0;
      req_loco_address       <= '0;
      req_step_mode          <= MODE_14;
      req_forward            <= 1'b0;
      req_speed_step         <= '0;
      req_function_bits_low  <= '0;
      req_function_bits_high <= '0;
      req_packet_kind        <= KIND_SPEED;
      hold_results = 1'b0;
      no_gaps      = 1'b0;
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // address forms and speed encodings
      offer_fields(14'd0, MODE_14, 1'b1, 7'd0, '1, '1, KIND_SPEED);
      offer_fields(14'd127, MODE_14, 1'b0, 7'd14, '0, '0, KIND_SPEED);
      offer_fields(14'd128, MODE_14, 1'b1, 7'd127, 64'd1, '0, KIND_SPEED);
      offer_fields(14'd10239, MODE_28, 1'b1, 7'd0, '0, '0, KIND_SPEED);
      offer_fields(14'h3fff, MODE_28, 1'b0, 7'd1, '0, '0, KIND_SPEED);
      offer_fields(14'd3, MODE_28, 1'b1, 7'd28, '0, '0, KIND_SPEED);
      offer_fields(14'd3, MODE_28, 1'b0, 7'd127, '0, '0, KIND_SPEED);
      offer_fields(14'd3, MODE_128, 1'b1, 7'd0, '0, '0, KIND_SPEED);
      offer_fields(14'd3, MODE_128, 1'b0, 7'd1, '0, '0, KIND_SPEED);
      offer_fields(14'd3, MODE_128, 1'b1, 7'd126, '0, '0, KIND_SPEED);
      offer_fields(14'd3, MODE_128, 1'b1, 7'd127, '0, '0, KIND_SPEED);
      offer_fields(14'd77, MODE_SPARE, 1'b1, 7'd5, 64'd1, '0, KIND_SPEED);
      // every function group, all-ones and alternating patterns
      for (int k = int'(KIND_F0_4); k <= int'(KIND_F61_68); k++) begin
         if (k % 2 == 1) offer_fields(14'd200, MODE_14, 1'b0, 7'd0, '1, '1, 4'(k));
         else offer_fields(14'd9, MODE_14, 1'b0, 7'd0, 64'h5555_5555_5555_5555, 5'h15,
                           4'(k));
      end
      offer_fields(14'd42, MODE_28, 1'b1, 7'd10, '0, '0, KIND_F61_68 + 4'd1);
      offer_fields(14'd4242, MODE_128, 1'b0, 7'd60, '0, '0, KIND_LAST);
      wait_for_drain();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 40) begin
            hold_results = 1'b1;
            no_gaps      = 1'b1;
         end
         if (i == 52) no_gaps = 1'b0;
         if (i == 100) wait_for_drain();
         if (i == 120) no_gaps = 1'b1;
         if (i == 132) no_gaps = 1'b0;
         offer_request(random_request());
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d request transfers, %0d packet bytes, %0d long-address packets",
               sb.packets_noted, sb.bytes_checked, sb.long_address_packets);
      $display("packet kind codes seen: %0d of 16, %s",
               $countones(sb.kinds_noted), "with a long result hold-off and a drained pause");
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
